[hdl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int unsigned DefWidth = 32;
    localparam int unsigned KindW    = 3;
    localparam int unsigned StatW    = 2;

    localparam logic [KindW-1:0] K_REDUCE = 3'd0;
    localparam logic [KindW-1:0] K_ADD    = 3'd1;
    localparam logic [KindW-1:0] K_SUB    = 3'd2;
    localparam logic [KindW-1:0] K_MUL    = 3'd3;
    localparam logic [KindW-1:0] K_DIV    = 3'd4;

    localparam logic [StatW-1:0] ST_OK   = 2'd0;
    localparam logic [StatW-1:0] ST_ZERO = 2'd1;
    localparam logic [StatW-1:0] ST_OVF  = 2'd2;
endpackage

[hdl/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Reduce, add, subtract, multiply and divide fractions, canonical results.
// ----------------------------------------------------------------------------
// channel  | handshake            | words
// command  | start, busy          | i_kind, i_a_num, i_a_den, i_b_num, i_b_den
// result   | o_valid (one cycle)  | o_res_num, o_res_den, o_status
//
// A command runs from accept to strobe through the bit-serial multiplies
// (three for add and subtract, two otherwise), the binary gcd steps, two
// divisions by the gcd and an output state; the gcd, the divisions and the
// add/subtract sign compare share one subtractor. Zero-denominator items
// strobe in the cycle after accept. Reset is synchronous, active low.
// The receiver cannot stall; each result is shown for one cycle.
module rational_arithmetic_unit #(
    parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_kind,
    input  logic signed [31:0]        i_a_num,
    input  logic signed [31:0]        i_a_den,
    input  logic signed [31:0]        i_b_num,
    input  logic signed [31:0]        i_b_den,
    output logic                      o_valid,
    output logic signed [31:0]        o_res_num,
    output logic [30:0]               o_res_den,
    output logic [rau_pkg::StatW-1:0] o_status
);
    import rau_pkg::*;

    logic [WIDTH-1:0] c_num;
    logic [WIDTH-2:0] c_den;

    rau_core #(.WIDTH(WIDTH)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_an    (i_a_num[WIDTH-1:0]),
        .i_ad    (i_a_den[WIDTH-1:0]),
        .i_bn    (i_b_num[WIDTH-1:0]),
        .i_bd    (i_b_den[WIDTH-1:0]),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_num   (c_num),
        .o_den   (c_den),
        .o_status(o_status)
    );

    // sign-extend numerator, zero-extend denominator to port widths
    assign o_res_num = 32'(signed'(c_num));
    assign o_res_den = 31'(c_den);
endmodule

[hdl/rau_core.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic sequencer
// One shared 2*WIDTH-bit subtract/compare unit serves the add/sub sign compare,
// binary gcd and two restoring divisions; shift-add multiply, one bit a cycle.
// ----------------------------------------------------------------------------
module rau_core #(
    parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rau_pkg::KindW-1:0] i_kind,
    input  logic [WIDTH-1:0]         i_an,
    input  logic [WIDTH-1:0]         i_ad,
    input  logic [WIDTH-1:0]         i_bn,
    input  logic [WIDTH-1:0]         i_bd,
    output logic                     o_busy,
    output logic                     o_valid,
    output logic [WIDTH-1:0]         o_num,
    output logic [WIDTH-2:0]         o_den,
    output logic [rau_pkg::StatW-1:0] o_status
);
    import rau_pkg::*;

    localparam int unsigned W2 = 2 * WIDTH;
    localparam int unsigned CW = $clog2(W2 + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MDONE, S_GCD, S_DIVN, S_DIVD, S_DONE
    } t_state;

    t_state r_state;
    logic [KindW-1:0] r_kind;
    // multiply phase: r_step 0 = an*bd (or numerator), 1 = bn*ad, 2 = den
    logic [1:0]    r_step;
    logic [W2-1:0] r_acc, r_mc;
    logic [WIDTH-1:0] r_mp;
    logic [CW-1:0] r_cnt;
    logic [W2-1:0] r_p0;
    logic          r_nneg;
    logic [W2-1:0] r_num, r_den;
    // gcd (Euclid by subtraction with shifts: binary gcd)
    logic [W2-1:0] r_gx, r_gy, r_g;
    logic [CW-1:0] r_sh;
    // divider
    logic [W2-1:0] r_q, r_rem, r_dq;
    logic [W2-1:0] r_qn;
    logic [WIDTH-1:0] m_an, m_ad, m_bn, m_bd;
    logic          sa_n, sa_d, sb_n, sb_d;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic          r_an_s, r_bn_s;

    function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
        mag = v[WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        m_an = mag(i_an); m_ad = mag(i_ad); m_bn = mag(i_bn); m_bd = mag(i_bd);
        sa_n = i_an[WIDTH-1]; sa_d = i_ad[WIDTH-1];
        sb_n = i_bn[WIDTH-1]; sb_d = i_bd[WIDTH-1];
    end

    // shared subtract unit
    logic [W2-1:0] u_a, u_b, u_d;
    logic          u_ge;
    logic [W2:0]   rem_sh;
    always_comb begin
        rem_sh = {r_rem, r_qn[W2-1]};
        u_a = r_gx; u_b = r_gy;
        unique case (r_state)
            S_DIVN, S_DIVD: begin u_a = rem_sh[W2-1:0]; u_b = r_g; end
            S_MDONE:        begin u_a = r_p0; u_b = r_acc; end
            default:        begin u_a = r_gx; u_b = r_gy; end
        endcase
        u_d  = u_a - u_b;
        u_ge = (u_a >= u_b) || (r_state inside {S_DIVN, S_DIVD} && rem_sh[W2]);
    end

    logic          binop, zero_err;
    logic [W2-1:0] half;
    always_comb begin
        binop = (i_kind >= K_ADD) && (i_kind <= K_DIV);
        zero_err = (i_ad == '0) || (binop && i_bd == '0) || (i_kind == K_DIV && i_bn == '0);
        half = {{(W2-1){1'b0}}, 1'b1} << (WIDTH - 1);
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    if (zero_err) begin
                        o_valid <= 1'b1; o_num <= '0; o_den <= '0; o_status <= ST_ZERO;
                    end else begin
                        r_kind <= i_kind;
                        r_an <= m_an; r_ad <= m_ad; r_bn <= m_bn; r_bd <= m_bd;
                        r_an_s <= sa_n ^ sa_d;
                        r_bn_s <= sb_n ^ sb_d ^ (i_kind == K_SUB);
                        r_step <= 2'd0;
                        r_acc <= '0;
                        r_cnt <= '0;
                        unique case (i_kind)
                            K_ADD, K_SUB: begin r_mc <= W2'(m_an); r_mp <= m_bd; end
                            K_MUL:        begin r_mc <= W2'(m_an); r_mp <= m_bn; end
                            K_DIV:        begin r_mc <= W2'(m_an); r_mp <= m_bd; end
                            default: begin
                                r_mc <= W2'(m_an);
                                r_mp <= {{(WIDTH-1){1'b0}}, 1'b1};
                            end
                        endcase
                        r_state <= S_MUL;
                    end
                end
                // shift-add multiply, one multiplier bit a cycle
                S_MUL: begin
                    if (r_mp[0]) r_acc <= r_acc + r_mc;
                    r_mc <= r_mc << 1;
                    r_mp <= r_mp >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(WIDTH - 1)) r_state <= S_MDONE;
                end
                S_MDONE: begin
                    r_acc <= '0; r_cnt <= '0;
                    r_state <= S_MUL;
                    if (r_step == 2'd0) begin
                        r_p0 <= r_acc;
                        if (r_kind == K_ADD || r_kind == K_SUB) begin
                            r_step <= 2'd1;
                            r_mc <= W2'(r_bn); r_mp <= r_ad;
                        end else begin
                            r_num <= r_acc;
                            r_nneg <= (r_kind == K_MUL) ? (r_an_s ^ r_bn_s) :
                                      (r_kind == K_DIV) ? (r_an_s ^ r_bn_s) : r_an_s;
                            r_step <= 2'd2;
                            r_mc <= W2'(r_ad);
                            unique case (r_kind)
                                K_MUL:   r_mp <= r_bd;
                                K_DIV:   r_mp <= r_bn;
                                default: r_mp <= {{(WIDTH-1){1'b0}}, 1'b1};
                            endcase
                        end
                    end else if (r_step == 2'd1) begin
                        // signed-magnitude sum of p0 (sign an) and acc (sign bn)
                        if (r_an_s == r_bn_s) begin
                            r_num <= r_p0 + r_acc; r_nneg <= r_an_s;
                        end else if (u_ge) begin
                            r_num <= u_d; r_nneg <= r_an_s;
                        end else begin
                            r_num <= r_acc - r_p0; r_nneg <= r_bn_s;
                        end
                        r_step <= 2'd2;
                        r_mc <= W2'(r_ad); r_mp <= r_bd;
                    end else begin
                        r_den <= r_acc;
                        r_gx <= r_num; r_gy <= r_acc; r_sh <= '0;
                        r_state <= S_GCD;
                    end
                end
                // binary gcd, one step a cycle; r_gy stays nonzero
                S_GCD: begin
                    if (r_gx == '0) begin
                        r_g <= r_gy << r_sh;
                        r_cnt <= '0; r_qn <= r_num; r_rem <= '0;
                        r_state <= S_DIVN;
                    end else if (!r_gx[0] && !r_gy[0]) begin
                        r_gx <= r_gx >> 1; r_gy <= r_gy >> 1; r_sh <= r_sh + 1'b1;
                    end else if (!r_gx[0]) begin
                        r_gx <= r_gx >> 1;
                    end else if (!r_gy[0]) begin
                        r_gy <= r_gy >> 1;
                    end else if (u_ge) begin
                        r_gx <= u_d >> 1;
                    end else begin
                        r_gx <= (r_gy - r_gx) >> 1; r_gy <= r_gx;
                    end
                end
                // restoring division by the gcd, one quotient bit a cycle
                S_DIVN, S_DIVD: begin
                    r_rem <= u_ge ? u_d : rem_sh[W2-1:0];
                    r_qn  <= {r_qn[W2-2:0], u_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W2 - 1)) begin
                        r_cnt <= '0; r_rem <= '0;
                        if (r_state == S_DIVN) begin
                            r_q <= {r_qn[W2-2:0], u_ge};
                            r_qn <= r_den;
                            r_state <= S_DIVD;
                        end else begin
                            r_dq <= {r_qn[W2-2:0], u_ge};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_dq > half - 1'b1 ||
                        ((r_nneg && r_q != '0) ? (r_q > half) : (r_q > half - 1'b1))) begin
                        o_num <= '0; o_den <= '0; o_status <= ST_OVF;
                    end else begin
                        o_num <= (r_nneg && r_q != '0) ? WIDTH'(~r_q + 1'b1) : r_q[WIDTH-1:0];
                        o_den <= r_dq[WIDTH-2:0];
                        o_status <= ST_OK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[test/rational_arithmetic_unit_tb.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives reduce/add/sub/mul/div commands with random gaps, predicts each
// canonical fraction and status, and checks every strobed result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int unsigned W = DefWidth;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [StatW-1:0]   status;
    } t_fraction;

    // Scoreboard: queue of predicted fractions, compared in order
    class fraction_board;
        t_fraction pending[$];
        int        faults;
        int        checked;

        function new();
            faults  = 0;
            checked = 0;
        endfunction

        // Load a word as sign and magnitude at width W
        function void split(input logic [31:0] raw, output bit neg,
                            output logic [63:0] mag);
            logic [63:0] v;
            logic [63:0] msk;
            msk = (64'd1 << W) - 1;
            v   = {32'd0, raw} & msk;
            neg = v[W-1];
            mag = neg ? (msk + 1 - v) : v;
        endfunction

        // Exact canonical fraction for one command word
        function t_fraction work_out(input logic [2:0] kind,
                logic [31:0] an_r, ad_r, bn_r, bd_r);
            t_fraction   r;
            bit          an_n, ad_n, bn_n, bd_n, nn, dn, p_n, q_n;
            logic [63:0] an, ad, bn, bd, nm, dm, p, q, x, y, t, half;
            bit          two;
            split(an_r, an_n, an);
            split(ad_r, ad_n, ad);
            split(bn_r, bn_n, bn);
            split(bd_r, bd_n, bd);
            two = (kind >= K_ADD && kind <= K_DIV);
            r = '{0, 0, ST_ZERO};
            if (ad == 0 || (two && bd == 0) || (kind == K_DIV && bn == 0))
                return r;
            if (ad_n) an_n = !an_n;
            if (bd_n) bn_n = !bn_n;
            dn = 0;
            case (kind)
                K_ADD, K_SUB: begin
                    if (kind == K_SUB) bn_n = !bn_n;
                    p = an * bd; p_n = an_n;
                    q = bn * ad; q_n = bn_n;
                    if (p_n == q_n) begin nm = p + q; nn = p_n; end
                    else if (p >= q) begin nm = p - q; nn = p_n; end
                    else begin nm = q - p; nn = q_n; end
                    dm = ad * bd;
                end
                K_MUL: begin nm = an * bn; nn = an_n != bn_n; dm = ad * bd; end
                K_DIV: begin
                    nm = an * bd; nn = an_n;
                    dm = ad * bn; dn = bn_n;
                end
                default: begin nm = an; nn = an_n; dm = ad; end
            endcase
            if (dn) nn = !nn;
            x = nm; y = dm;
            while (y != 0) begin t = x % y; x = y; y = t; end
            nm = nm / x; dm = dm / x;
            if (nm == 0) nn = 0;
            half = 64'd1 << (W - 1);
            r.status = ST_OVF;
            if (dm > half - 1) return r;
            if (nn ? (nm > half) : (nm > half - 1)) return r;
            r.num    = nn ? (32'(0 - nm)) : nm[31:0];
            r.den    = dm[30:0];
            r.status = ST_OK;
            return r;
        endfunction

        function void note_command(input logic [2:0] kind,
                logic [31:0] an, ad, bn, bd);
            pending.push_back(work_out(kind, an, ad, bn, bd));
        endfunction

        task report(input string what);
            faults++;
            $display("t=%0t error: %s", $realtime, what);
        endtask

        task check_result(input t_fraction got);
            t_fraction want;
            checked++;
            if (pending.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (got.num !== want.num)
                report($sformatf("num %0d want %0d", got.num, want.num));
            if (got.den !== want.den)
                report($sformatf("den %0d want %0d", got.den, want.den));
            if (got.status !== want.status)
                report($sformatf("status %0d want %0d", got.status, want.status));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_kind;
    logic signed [31:0] i_a_num, i_a_den, i_b_num, i_b_den;
    logic               o_valid;
    logic signed [31:0] o_res_num;
    logic [30:0]        o_res_den;
    logic [StatW-1:0]   o_status;

    fraction_board board;
    int            n_items;
    int            kind_seen[8];

    rational_arithmetic_unit #(.WIDTH(W)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den), .o_valid(o_valid),
        .o_res_num(o_res_num), .o_res_den(o_res_den), .o_status(o_status)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            board.check_result('{o_res_num, o_res_den, o_status});
    end

    // One command word: optional gap with start low, then hold start until accepted
    task send_command(input logic [2:0] kind, input logic [31:0] an, ad, bn, bd);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_kind  <= kind;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        board.note_command(kind, an, ad, bn, bd);
        kind_seen[kind]++;
        n_items++;
    endtask

    // Random operand: mostly small values so gcds cancel, some full range
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            2:       return 32'(-int'($urandom_range(0, 1000)));
            3:       return 32'($urandom_range(0, 3)) - 32'd1;
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic logic [31:0] pick_den();
        if ($urandom_range(0, 30) == 0) return 32'd0;
        return pick_value();
    endfunction

    // Stimulus
    initial begin
        logic [31:0] big, neg_big;
        board   = new();
        n_items = 0;
        start   = 1'b0;
        i_kind  = K_REDUCE;
        i_a_num = 0; i_a_den = 0; i_b_num = 0; i_b_den = 0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        big     = 32'h7fff_ffff;
        neg_big = 32'h8000_0000;
        // Directed: each operation, zero denominators, divide by zero,
        // overflow, field extremes and unused kinds
        send_command(K_REDUCE, 6, -4, 0, 0);
        send_command(K_REDUCE, 0, -7, 0, 0);
        send_command(K_REDUCE, 5, 0, 1, 1);
        send_command(K_REDUCE, neg_big, 1, 0, 0);
        send_command(K_REDUCE, neg_big, -1, 0, 0);
        send_command(K_REDUCE, 3, neg_big, 0, 0);
        send_command(K_REDUCE, neg_big, neg_big, 0, 0);
        send_command(K_ADD, 1, 2, 1, 3);
        send_command(K_ADD, 1, 2, 1, 0);
        send_command(K_ADD, big, 1, big, 1);
        send_command(K_ADD, neg_big, 1, neg_big, 1);
        send_command(K_SUB, 1, 2, 1, 3);
        send_command(K_SUB, 1, 3, 1, 2);
        send_command(K_SUB, neg_big, 1, 1, 1);
        send_command(K_MUL, 2, 3, 3, 4);
        send_command(K_MUL, big, 1, big, 1);
        send_command(K_MUL, -1, 1, neg_big, 1);
        send_command(K_DIV, 1, 2, 3, 4);
        send_command(K_DIV, 1, 2, 0, 4);
        send_command(K_DIV, 1, 2, 3, 0);
        send_command(K_DIV, 1, big, big, 1);
        send_command(3'd5, 4, 8, 1, 1);
        send_command(3'd6, 4, -8, 1, 0);
        send_command(3'd7, 32'hffff_ffff, 32'hffff_ffff, 0, 0);

        // Random commands
        repeat (1100)
            send_command($urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4)),
                         pick_value(), pick_den(), pick_value(), pick_den());
        start <= 1'b0;

        // Drain
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("Ran %0d commands (reduce %0d, add %0d, sub %0d, mul %0d, div %0d),",
                 n_items, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
                 kind_seen[4]);
        $display("%0d results checked, %0d faults.", board.checked, board.faults);
        if (board.faults == 0)
            $display("rational_arithmetic_unit: match");
        else
            $display("rational_arithmetic_unit: mismatch");
        $finish;
    end

    // Watchdog: ~1125 items with gaps, with a limit set well over their run time
    initial begin
        #20ms;
        $display("rational_arithmetic_unit: mismatch");
        $finish;
    end
endmodule
